[hdl/tdpt_pkg.sv]
// ----------------------------------------------------------------------------
// Trial division prime test: shared constants
// Widths and verdict codes for the bit-serial trial division unit.
// ----------------------------------------------------------------------------
package tdpt_pkg;

	localparam int VALUE_WIDTH = 32;
	// Largest divisor tried is floor(sqrt(2**(VALUE_WIDTH-1))) + 1
	localparam int DIV_WIDTH   = VALUE_WIDTH / 2 + 1;
	localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

	localparam logic [1:0] VERDICT_PRIME     = 2'd0;
	localparam logic [1:0] VERDICT_COMPOSITE = 2'd1;
	localparam logic [1:0] VERDICT_INVALID   = 2'd2;

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [DIV_WIDTH-1:0]   divisor_t;

endpackage

[hdl/trial_division_prime_test_unit.sv]
// ----------------------------------------------------------------------------
// Trial division prime test unit
// Classifies a signed integer as prime, composite or invalid, using a
// bit-serial restoring divider that tries divisors from 2 upward.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------
//  input    | in_valid / in_ready  | value   [VALUE_WIDTH-1:0] signed
//  output   | out_valid / out_ready| verdict [1:0]
//
// Invalid inputs (value <= 1) give a registered result in the cycle after acceptance.
// Otherwise each trial divisor runs through the serial divider, one bit of
// the dividend per cycle, followed by a check state that ends the search
// with a verdict or moves on to the next divisor and reruns the divider.
// One item is in work at a time; in_ready is low while the divider runs or
// while an earlier result waits to be taken. Reset clears all control state.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [tdpt_pkg::VALUE_WIDTH-1:0] value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       verdict
);

	localparam int W  = tdpt_pkg::VALUE_WIDTH;
	localparam int DW = tdpt_pkg::DIV_WIDTH;
	localparam int CW = tdpt_pkg::CNT_WIDTH;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DIVIDE = 2'd1;
	localparam logic [1:0] ST_CHECK  = 2'd2;

	logic [1:0]          state_q;
	tdpt_pkg::value_t    num_q;
	tdpt_pkg::value_t    shift_q;
	tdpt_pkg::value_t    quo_q;
	tdpt_pkg::divisor_t  div_q;
	tdpt_pkg::divisor_t  rem_q;
	logic [CW-1:0]       cnt_q;
	logic                out_valid_q;
	logic [1:0]          verdict_q;

	logic                in_fire;
	logic                in_bad;
	logic [DW:0]         trial;
	logic                trial_ge;
	logic [DW:0]         trial_diff;
	logic                div_gt_quo;
	logic                result_load;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign in_bad    = value[W-1] || (value <= $signed(W'(1)));
	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

	// Present a result on an invalid input or when the search ends
	assign result_load = (in_fire && in_bad) ||
		((state_q == ST_CHECK) && (div_gt_quo || rem_q == '0));

	// One restoring step: bring down the next dividend bit
	assign trial      = {rem_q, shift_q[W-1]};
	assign trial_ge   = trial >= {1'b0, div_q};
	assign trial_diff = trial - {1'b0, div_q};
	assign div_gt_quo = {{(W-DW){1'b0}}, div_q} > quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			div_q       <= DW'(2);
		end else begin
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && !in_bad) begin
						state_q <= ST_DIVIDE;
						cnt_q   <= '0;
						div_q   <= DW'(2);
					end
				end
				ST_DIVIDE: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(W - 1)) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (div_gt_quo || rem_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						// advance to the next divisor and rerun the divider
						div_q   <= div_q + DW'(1);
						cnt_q   <= '0;
						state_q <= ST_DIVIDE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					num_q   <= value;
					shift_q <= value;
					rem_q   <= '0;
					quo_q   <= '0;
					if (in_bad) begin
						verdict_q <= tdpt_pkg::VERDICT_INVALID;
					end
				end
			end
			ST_DIVIDE: begin
				rem_q   <= trial_ge ? trial_diff[DW-1:0] : trial[DW-1:0];
				quo_q   <= {quo_q[W-2:0], trial_ge};
				shift_q <= {shift_q[W-2:0], 1'b0};
			end
			ST_CHECK: begin
				if (div_gt_quo) begin
					verdict_q <= tdpt_pkg::VERDICT_PRIME;
				end else if (rem_q == '0) begin
					verdict_q <= tdpt_pkg::VERDICT_COMPOSITE;
				end else begin
					shift_q <= num_q;
					rem_q   <= '0;
					quo_q   <= '0;
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE) |-> (rem_q < div_q))
		else $error("partial remainder not below divisor");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input ready while division runs");

	a_div_at_least_two: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (div_q >= DW'(2)))
		else $error("trial divisor below two");

	a_prime_reported: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && div_gt_quo) |=>
			(out_valid_q && verdict_q == tdpt_pkg::VERDICT_PRIME))
		else $error("prime verdict not presented");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the trial division prime test unit
// Drives signed values through the valid/ready input and predicts each
// verdict by trial division. Results are checked in order against the
// predictions. Both sides idle at random, and one long output stall
// forces the unit to hold back its input.
// ----------------------------------------------------------------------------
module tb;

	typedef struct {
		tdpt_pkg::value_t value;
		logic [1:0]       verdict;
	} verdict_entry_t;

	logic                                    clk;
	logic                                    arst_n;
	logic                                    in_valid;
	logic                                    in_ready;
	logic signed [tdpt_pkg::VALUE_WIDTH-1:0] value;
	logic                                    out_valid;
	logic                                    out_ready;
	logic [1:0]                              verdict;

	verdict_entry_t pending_verdicts[$];
	int             mismatch_count;
	bit             sender_idle_en;
	bit             receiver_idle_en;
	int             hold_cycles;

	trial_division_prime_test_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.verdict   (verdict)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Smallest divisor search, bounded by d <= n / d so the square never overflows
	function automatic logic [1:0] classify_value(tdpt_pkg::value_t v);
		longint unsigned n;
		longint unsigned d;
		if (v[tdpt_pkg::VALUE_WIDTH-1] || v <= 1)
			return tdpt_pkg::VERDICT_INVALID;
		n = v;
		d = 2;
		while (d <= n / d) begin
			if (n % d == 0)
				return tdpt_pkg::VERDICT_COMPOSITE;
			d++;
		end
		return tdpt_pkg::VERDICT_PRIME;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		verdict_entry_t head;
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch($sformatf("verdict %0d with no item pending", verdict));
			end else begin
				head = pending_verdicts.pop_front();
				if (verdict !== head.verdict)
					report_mismatch($sformatf("value %0d: verdict %0d, predicted %0d",
						$signed(head.value), verdict, head.verdict));
			end
		end
	end

	// Output side: random stall bursts, or a long hold when one is requested
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles != 0) begin
				out_ready <= 1'b0;
				repeat (hold_cycles - 1) @(negedge clk);
				hold_cycles = 0;
			end else if (receiver_idle_en && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one item and hold it until accepted; junk rides on value while idle
	task automatic send_value(input tdpt_pkg::value_t v);
		verdict_entry_t entry;
		@(negedge clk);
		if (sender_idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			value    <= $urandom;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		entry.value   = v;
		entry.verdict = classify_value(v);
		pending_verdicts.push_back(entry);
	endtask

	function automatic tdpt_pkg::value_t random_value();
		int unsigned factors[6] = '{2, 3, 5, 7, 11, 13};
		int unsigned f;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			return {1'b1, 31'($urandom)};
		if (pick < 20)
			return tdpt_pkg::value_t'($urandom_range(0, 1));
		if (pick < 55)
			return tdpt_pkg::value_t'($urandom_range(2, 4095));
		if (pick < 70)
			return tdpt_pkg::value_t'($urandom_range(4096, 65535));
		// large values with a small factor keep the search short
		f = factors[$urandom_range(0, 5)];
		return tdpt_pkg::value_t'($urandom_range(1, 32'h7FFF_FFFF / f) * f);
	endfunction

	task automatic test_invalid_inputs();
		send_value(tdpt_pkg::value_t'(32'h8000_0000));
		send_value(tdpt_pkg::value_t'(32'hFFFF_FFFF));
		send_value(tdpt_pkg::value_t'(32'hAAAA_AAAA));
		send_value(tdpt_pkg::value_t'(0));
		send_value(tdpt_pkg::value_t'(1));
	endtask

	task automatic test_small_values();
		int unsigned smalls[9] = '{2, 3, 4, 5, 9, 25, 49, 121, 997 * 997};
		foreach (smalls[i])
			send_value(tdpt_pkg::value_t'(smalls[i]));
		send_value(tdpt_pkg::value_t'(65521));
		send_value(tdpt_pkg::value_t'(65537));
	endtask

	task automatic test_extremes();
		send_value(tdpt_pkg::value_t'(32'h7FFF_FFFE));
		send_value(tdpt_pkg::value_t'(32'h5555_5555));
		send_value(tdpt_pkg::value_t'(32'h2AAA_AAAA));
		// largest positive value is prime: the full divisor sweep
		send_value(tdpt_pkg::value_t'(32'h7FFF_FFFF));
	endtask

	task automatic test_output_stall();
		hold_cycles = 400;
		repeat (8) send_value(tdpt_pkg::value_t'($urandom_range(0, 1)));
		repeat (4) send_value(tdpt_pkg::value_t'($urandom_range(2, 200)));
	endtask

	task automatic test_random(input int count);
		repeat (count) send_value(random_value());
	endtask

	initial begin
		mismatch_count   = 0;
		hold_cycles      = 0;
		sender_idle_en   = 1'b0;
		receiver_idle_en = 1'b0;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		value    = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_invalid_inputs();
		test_small_values();
		sender_idle_en   = 1'b1;
		receiver_idle_en = 1'b1;
		test_extremes();
		test_output_stall();
		test_random(25);
		sender_idle_en   = 1'b0;
		receiver_idle_en = 1'b0;
		test_random(15);
		sender_idle_en   = 1'b1;
		receiver_idle_en = 1'b1;
		test_random(15);
		// last stretch runs without idling
		sender_idle_en   = 1'b0;
		receiver_idle_en = 1'b0;
		test_random(15);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS trial_division_prime_test_unit");
		else
			$display("FAIL trial_division_prime_test_unit");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("ERROR: timeout with %0d verdicts pending", pending_verdicts.size());
		$display("FAIL trial_division_prime_test_unit");
		$finish;
	end

endmodule

[sim.f]
hdl/tdpt_pkg.sv
hdl/trial_division_prime_test_unit.sv
verif/tb.sv
